// ===== rtl/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared constants for the triangle / box overlap pipeline.
// ----------------------------------------------------------------------------
package tbo_pkg;

   localparam int COORD_BITS_DEF = 24;

   localparam logic CMD_LOAD_BOX = 1'b0;
   localparam logic CMD_TEST_TRI = 1'b1;

   // accept edge to result strobe edge
   localparam int PIPE_LATENCY = 8;

endpackage

// ===== rtl/triangle_box_overlap.sv =====
// ----------------------------------------------------------------------------
// triangle_box_overlap
// Separating-axis overlap test of a triangle against a stored box.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start high and busy low. busy is
//   tied low: the pipeline takes an item in every cycle.
//   req_cmd = load box stores req_a_* as the box centre and req_b_* as the
//   half extents (a negative half extent is stored as zero); it gives no
//   result. req_cmd = test triangle takes vertices req_a_*, req_b_*, req_c_*.
//   A test item gives one result: rsp_strobe is high for one cycle with
//   rsp_overlap when the item leaves the result stage. Touching counts as
//   overlap. A test sees the box from the last load taken before it.
//   Throughput is one item per cycle; the eight register stages (centre
//   subtract, edges and box axes, products, sums, edge axes and normal
//   partial products, normal dot terms, normal dot sums, result) set the
//   latency.
//   Reset clears the stored box to a point at the origin and empties the
//   pipeline. The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module triangle_box_overlap #(
   parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_a_z,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_b_z,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_c_z,
   output logic                         rsp_strobe,
   output logic                         rsp_overlap
);

   localparam int W   = COORD_BITS;
   localparam int VW  = W + 1;          // vertex relative to centre
   localparam int EW  = W + 2;          // edge
   localparam int HW  = W - 1;          // half extent
   localparam int MW  = VW + EW;        // edge axis product
   localparam int PW  = MW + 1;         // edge axis projection
   localparam int RW  = HW + EW;        // edge axis radius product
   localparam int NPW = 2 * EW;         // normal product
   localparam int NW  = NPW + 1;        // normal component
   localparam int K   = W + 3;          // split point of normal
   localparam int NHW = NW - K;
   localparam int LW  = VW + K + 1;
   localparam int QW  = VW + NHW;
   localparam int RLW = HW + K;
   localparam int RHW = HW + NHW;
   localparam int DW  = 3 * W + 9;      // normal dot and radius
   localparam int LAT = tbo_pkg::PIPE_LATENCY;

   logic accept, accept_test, accept_load;
   logic signed [W-1:0] vert [3][3];

   // stored box
   logic signed [W-1:0]  box_centre_ff [3];
   logic        [HW-1:0] box_half_ff   [3];

   logic [7:1] vld_ff;
   logic [7:1] vld_in;

   logic signed [VW-1:0]  v1_in [3][3], v1_ff [3][3];
   logic        [HW-1:0]  h1_ff [3];
   logic signed [VW-1:0]  v2_ff [3][3];
   logic signed [EW-1:0]  e2_in [3][3], e2_ff [3][3];
   logic        [HW-1:0]  h2_ff [3];
   logic                  ok2_in, ok2_ff;
   logic        [2:0]     box_ax_ok;
   logic        [EW-1:0]  ae2 [3][3];
   logic signed [MW-1:0]  mpa3_in [3][3][3], mpa3_ff [3][3][3];
   logic signed [MW-1:0]  mpb3_in [3][3][3], mpb3_ff [3][3][3];
   logic        [RW-1:0]  rpa3_in [3][3], rpa3_ff [3][3];
   logic        [RW-1:0]  rpb3_in [3][3], rpb3_ff [3][3];
   logic signed [NPW-1:0] npa3_in [3], npa3_ff [3];
   logic signed [NPW-1:0] npb3_in [3], npb3_ff [3];
   logic signed [VW-1:0]  v3_ff [3][3];
   logic        [HW-1:0]  h3_ff [3];
   logic                  ok3_ff;
   logic signed [PW-1:0]  p4_in [3][3][3], p4_ff [3][3][3];
   logic        [RW:0]    r4_in [3][3], r4_ff [3][3];
   logic signed [NW-1:0]  n4_in [3], n4_ff [3];
   logic signed [VW-1:0]  v4_ff [3][3];
   logic        [HW-1:0]  h4_ff [3];
   logic                  ok4_ff;
   logic        [8:0]     edge_ax_ok;
   logic                  ok5_in, ok5_ff;
   logic        [NW-1:0]  an4 [3];
   logic signed [LW-1:0]  dl5_in [3][3], dl5_ff [3][3];
   logic signed [QW-1:0]  dh5_in [3][3], dh5_ff [3][3];
   logic        [RLW-1:0] rl5_in [3], rl5_ff [3];
   logic        [RHW-1:0] rh5_in [3], rh5_ff [3];
   logic signed [DW-1:0]  dc6_in [3][3], dc6_ff [3][3];
   logic        [DW-1:0]  rc6_in [3], rc6_ff [3];
   logic                  ok6_ff;
   logic signed [DW-1:0]  d7_in [3], d7_ff [3];
   logic        [DW-1:0]  rn7_in, rn7_ff;
   logic                  ok7_ff;
   logic signed [DW-1:0]  rn_s, rn_neg;
   logic                  norm_ok;
   logic                  rsp_strobe_ff, rsp_overlap_ff;

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign accept_test = accept && (req_cmd == tbo_pkg::CMD_TEST_TRI);
   assign accept_load = accept && (req_cmd == tbo_pkg::CMD_LOAD_BOX);
   assign vld_in      = {vld_ff[6:1], accept_test};

   assign vert[0][0] = req_a_x;
   assign vert[0][1] = req_a_y;
   assign vert[0][2] = req_a_z;
   assign vert[1][0] = req_b_x;
   assign vert[1][1] = req_b_y;
   assign vert[1][2] = req_b_z;
   assign vert[2][0] = req_c_x;
   assign vert[2][1] = req_c_y;
   assign vert[2][2] = req_c_z;

   genvar gk, gi, gj, gt;
   generate
      for (gk = 0; gk < 3; gk++) begin : g_vert
         for (gi = 0; gi < 3; gi++) begin : g_comp
            assign v1_in[gk][gi] = VW'(vert[gk][gi]) - VW'(box_centre_ff[gi]);
         end
      end

      // edges and box face axes
      for (gi = 0; gi < 3; gi++) begin : g_edge
         assign e2_in[0][gi] = EW'(v1_ff[1][gi]) - EW'(v1_ff[0][gi]);
         assign e2_in[1][gi] = EW'(v1_ff[2][gi]) - EW'(v1_ff[1][gi]);
         assign e2_in[2][gi] = EW'(v1_ff[0][gi]) - EW'(v1_ff[2][gi]);
      end
      for (gt = 0; gt < 3; gt++) begin : g_box_ax
         logic signed [VW-1:0] r, rn;
         assign r  = $signed({2'b00, h1_ff[gt]});
         assign rn = -r;
         assign box_ax_ok[gt] =
            (v1_ff[0][gt] <= r || v1_ff[1][gt] <= r || v1_ff[2][gt] <= r) &&
            (v1_ff[0][gt] >= rn || v1_ff[1][gt] >= rn || v1_ff[2][gt] >= rn);
      end
      assign ok2_in = &box_ax_ok;

      // products: axis t, components a and b follow it cyclically
      for (gj = 0; gj < 3; gj++) begin : g_abs_e
         for (gi = 0; gi < 3; gi++) begin : g_c
            assign ae2[gj][gi] = e2_ff[gj][gi][EW-1] ? EW'(-e2_ff[gj][gi])
                                                     : EW'(e2_ff[gj][gi]);
         end
      end
      for (gt = 0; gt < 3; gt++) begin : g_ax
         localparam int A = (gt + 1) % 3;
         localparam int B = (gt + 2) % 3;
         for (gj = 0; gj < 3; gj++) begin : g_e
            for (gk = 0; gk < 3; gk++) begin : g_v
               assign mpa3_in[gj][gt][gk] = v2_ff[gk][A] * e2_ff[gj][B];
               assign mpb3_in[gj][gt][gk] = v2_ff[gk][B] * e2_ff[gj][A];
               assign p4_in[gj][gt][gk]   = PW'(mpa3_ff[gj][gt][gk])
                                          - PW'(mpb3_ff[gj][gt][gk]);
            end
            assign rpa3_in[gj][gt] = h2_ff[A] * ae2[gj][B];
            assign rpb3_in[gj][gt] = h2_ff[B] * ae2[gj][A];
            assign r4_in[gj][gt]   = (RW+1)'(rpa3_ff[gj][gt])
                                   + (RW+1)'(rpb3_ff[gj][gt]);
         end
         // triangle normal, component t
         assign npa3_in[gt] = e2_ff[0][A] * e2_ff[1][B];
         assign npb3_in[gt] = e2_ff[0][B] * e2_ff[1][A];
         assign n4_in[gt]   = NW'(npa3_ff[gt]) - NW'(npb3_ff[gt]);
      end

      // edge cross axes
      for (gj = 0; gj < 3; gj++) begin : g_eok
         for (gt = 0; gt < 3; gt++) begin : g_t
            logic signed [PW-1:0] r, rn;
            assign r  = $signed(PW'(r4_ff[gj][gt]));
            assign rn = -r;
            assign edge_ax_ok[3*gj+gt] =
               (p4_ff[gj][gt][0] <= r || p4_ff[gj][gt][1] <= r ||
                p4_ff[gj][gt][2] <= r) &&
               (p4_ff[gj][gt][0] >= rn || p4_ff[gj][gt][1] >= rn ||
                p4_ff[gj][gt][2] >= rn);
         end
      end
      assign ok5_in = ok4_ff && (&edge_ax_ok);

      // normal split in two halves to keep the multipliers narrow
      for (gi = 0; gi < 3; gi++) begin : g_npart
         assign an4[gi] = n4_ff[gi][NW-1] ? NW'(-n4_ff[gi]) : NW'(n4_ff[gi]);
         for (gk = 0; gk < 3; gk++) begin : g_v
            assign dl5_in[gk][gi] = v4_ff[gk][gi] * $signed({1'b0, n4_ff[gi][K-1:0]});
            assign dh5_in[gk][gi] = v4_ff[gk][gi] * $signed(n4_ff[gi][NW-1:K]);
            assign dc6_in[gk][gi] = (DW'(dh5_ff[gk][gi]) <<< K) + DW'(dl5_ff[gk][gi]);
         end
         assign rl5_in[gi] = h4_ff[gi] * an4[gi][K-1:0];
         assign rh5_in[gi] = h4_ff[gi] * an4[gi][NW-1:K];
         assign rc6_in[gi] = (DW'(rh5_ff[gi]) << K) + DW'(rl5_ff[gi]);
      end
      for (gk = 0; gk < 3; gk++) begin : g_dot
         assign d7_in[gk] = dc6_ff[gk][0] + dc6_ff[gk][1] + dc6_ff[gk][2];
      end
   endgenerate

   assign rn7_in = rc6_ff[0] + rc6_ff[1] + rc6_ff[2];
   assign rn_s   = $signed(rn7_ff);
   assign rn_neg = -rn_s;
   assign norm_ok = (d7_ff[0] <= rn_s || d7_ff[1] <= rn_s || d7_ff[2] <= rn_s) &&
                    (d7_ff[0] >= rn_neg || d7_ff[1] >= rn_neg || d7_ff[2] >= rn_neg);

   // control and stored box
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            box_centre_ff[i] <= '0;
            box_half_ff[i]   <= '0;
         end
      end else begin
         vld_ff        <= vld_in;
         rsp_strobe_ff <= vld_ff[7];
         if (accept_load) begin
            for (int i = 0; i < 3; i++) begin
               box_centre_ff[i] <= vert[0][i];
               box_half_ff[i]   <= vert[1][i][W-1] ? '0 : vert[1][i][HW-1:0];
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            v1_ff[k][i]  <= v1_in[k][i];
            v2_ff[k][i]  <= v1_ff[k][i];
            v3_ff[k][i]  <= v2_ff[k][i];
            v4_ff[k][i]  <= v3_ff[k][i];
            e2_ff[k][i]  <= e2_in[k][i];
            rpa3_ff[k][i] <= rpa3_in[k][i];
            rpb3_ff[k][i] <= rpb3_in[k][i];
            r4_ff[k][i]  <= r4_in[k][i];
            dl5_ff[k][i] <= dl5_in[k][i];
            dh5_ff[k][i] <= dh5_in[k][i];
            dc6_ff[k][i] <= dc6_in[k][i];
            for (int m = 0; m < 3; m++) begin
               mpa3_ff[k][i][m] <= mpa3_in[k][i][m];
               mpb3_ff[k][i][m] <= mpb3_in[k][i][m];
               p4_ff[k][i][m]   <= p4_in[k][i][m];
            end
         end
         h1_ff[k]   <= box_half_ff[k];
         h2_ff[k]   <= h1_ff[k];
         h3_ff[k]   <= h2_ff[k];
         h4_ff[k]   <= h3_ff[k];
         npa3_ff[k] <= npa3_in[k];
         npb3_ff[k] <= npb3_in[k];
         n4_ff[k]   <= n4_in[k];
         rl5_ff[k]  <= rl5_in[k];
         rh5_ff[k]  <= rh5_in[k];
         rc6_ff[k]  <= rc6_in[k];
         d7_ff[k]   <= d7_in[k];
      end
      ok2_ff         <= ok2_in;
      ok3_ff         <= ok2_ff;
      ok4_ff         <= ok3_ff;
      ok5_ff         <= ok5_in;
      ok6_ff         <= ok5_ff;
      ok7_ff         <= ok6_ff;
      rn7_ff         <= rn7_in;
      rsp_overlap_ff <= ok7_ff && norm_ok;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_overlap = rsp_overlap_ff;

   // every result comes from a test item taken a fixed time before
   a_rsp_from_test: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept_test, LAT))
      else $error("result without a matching test item");

   // a box load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      accept_load |-> ##LAT !rsp_strobe)
      else $error("result produced by a box load");

   // negative half extent is clamped to zero
   a_half_clamp: assert property (@(posedge clock) disable iff (reset)
      (accept_load && req_b_x[W-1]) |=> (box_half_ff[0] == '0))
      else $error("negative half extent not clamped");

endmodule
